// ===== design/ints_pkg.sv =====
package ints_pkg;

   localparam int TAB_MASK        = 7;
   localparam int SPACE_BITS      = 12;
   localparam int LEVEL_OUT_BITS  = 6;
   localparam int REQ_DATA_BITS   = 8;
   localparam int RSP_DATA_BITS   = 24;
   localparam int CMD_BITS        = 2;
   localparam int STATUS_BITS     = 2;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_BYTE    = 2'd0,
      CMD_EMPTY   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK     = 2'd0,
      ST_DEEP   = 2'd1,
      ST_DEDENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FINISH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic finish_keep;
      logic finish_deep;
      logic push;
      logic srch_start;
      logic srch_read;
      logic srch_step;
      logic srch_done;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_empty;
      logic is_line;
      logic skip_line;
      logic col_eq;
      logic col_gt;
      logic too_deep;
      logic srch_stop;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== design/ints_ctrl.sv =====
module ints_ctrl
   import ints_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (stat.is_empty) begin
                  state_in = S_EMIT;
               end else if (stat.is_line) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (stat.skip_line || stat.col_eq || stat.col_gt) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (stat.srch_stop) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_FINISH: begin
            if (stat.skip_line || stat.col_eq) begin
               cmd.finish_keep = 1'b1;
            end else if (stat.col_gt) begin
               if (stat.too_deep) begin
                  cmd.finish_deep = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end else begin
               cmd.srch_start = 1'b1;
            end
         end
         S_SRCH_RD: begin
            cmd.srch_read = 1'b1;
         end
         S_SRCH_CMP: begin
            if (stat.srch_stop) begin
               cmd.srch_done = 1'b1;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         S_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/ints_dp.sv =====
module ints_dp
   import ints_pkg::*;
#(
   parameter int MAX_DEPTH   = 50,
   parameter int COLUMN_BITS = 12
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CMD_BITS-1:0]      req_cmd,
   input  logic [REQ_DATA_BITS-1:0] req_byte,
   input  logic                     req_last,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [LEVEL_OUT_BITS-1:0] rsp_level,
   output logic [SPACE_BITS-1:0]    rsp_spaces,
   output logic [STATUS_BITS-1:0]   rsp_status,
   input  ctrl_cmd_type             cmd,
   output dp_stat_type              stat
);

   localparam int LEVEL_BITS = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX   = {COLUMN_BITS{1'b1}};
   localparam logic [SPACE_BITS-1:0]  SPACE_MAX = {SPACE_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0]  TOP_LEVEL = LEVEL_BITS'(MAX_DEPTH - 1);

   logic [COLUMN_BITS-1:0] stack_mem [MAX_DEPTH];

   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [SPACE_BITS-1:0]  spaces_ff, spaces_in;
   logic                   lead_ff, lead_in;
   logic                   saw_ff, saw_in;
   logic                   cmt_ff, cmt_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [COLUMN_BITS-1:0] top_ff, top_in;
   logic [LEVEL_BITS-1:0]  srch_ff, srch_in;
   logic [COLUMN_BITS-1:0] rd_ff;
   logic [LEVEL_BITS-1:0]  res_level_ff, res_level_in;
   logic [SPACE_BITS-1:0]  res_spaces_ff, res_spaces_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_OUT_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic [SPACE_BITS-1:0]  rsp_spaces_ff, rsp_spaces_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic [COLUMN_BITS-1:0] tab_base;
   logic [COLUMN_BITS-1:0] tab_col;
   logic [COLUMN_BITS-1:0] srch_col;
   logic                   out_free;

   assign tab_base = column_ff | COLUMN_BITS'(TAB_MASK);
   assign tab_col  = (tab_base == COL_MAX) ? COL_MAX : tab_base + 1'b1;
   // Level zero is never written and always sits at column zero.
   assign srch_col = (srch_ff == '0) ? '0 : rd_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign stat.is_empty  = (req_cmd == CMD_EMPTY);
   assign stat.is_line   = (req_cmd == CMD_BYTE) && req_last;
   assign stat.skip_line = !saw_ff || cmt_ff;
   assign stat.col_eq    = (column_ff == top_ff);
   assign stat.col_gt    = (column_ff > top_ff);
   assign stat.too_deep  = (level_ff >= TOP_LEVEL);
   assign stat.srch_stop = (srch_ff == '0) || (column_ff >= srch_col);
   assign stat.out_free  = out_free;

   always_comb begin
      column_in     = column_ff;
      spaces_in     = spaces_ff;
      lead_in       = lead_ff;
      saw_in        = saw_ff;
      cmt_in        = cmt_ff;
      level_in      = level_ff;
      top_in        = top_ff;
      srch_in       = srch_ff;
      res_level_in  = res_level_ff;
      res_spaces_in = res_spaces_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_spaces_in = rsp_spaces_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.accept) begin
         case (req_cmd)
            CMD_RESTART: begin
               level_in = '0;
               top_in   = '0;
            end
            CMD_EMPTY: begin
               column_in     = '0;
               spaces_in     = '0;
               lead_in       = 1'b1;
               saw_in        = 1'b0;
               cmt_in        = 1'b0;
               res_level_in  = level_ff;
               res_spaces_in = '0;
               res_status_in = ST_OK;
            end
            CMD_BYTE: begin
               if (lead_ff) begin
                  if (req_byte == CHAR_SPACE) begin
                     if (column_ff != COL_MAX) begin
                        column_in = column_ff + 1'b1;
                     end
                     if (spaces_ff != SPACE_MAX) begin
                        spaces_in = spaces_ff + 1'b1;
                     end
                  end else if (req_byte == CHAR_TAB) begin
                     column_in = tab_col;
                     if (spaces_ff != SPACE_MAX) begin
                        spaces_in = spaces_ff + 1'b1;
                     end
                  end else begin
                     lead_in = 1'b0;
                     saw_in  = 1'b1;
                     cmt_in  = (req_byte == CHAR_HASH);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish_keep || cmd.finish_deep) begin
         res_level_in  = level_ff;
         res_spaces_in = spaces_ff;
         res_status_in = cmd.finish_deep ? ST_DEEP : ST_OK;
      end

      if (cmd.push) begin
         level_in      = level_ff + 1'b1;
         top_in        = column_ff;
         res_level_in  = level_ff + 1'b1;
         res_spaces_in = spaces_ff;
         res_status_in = ST_OK;
      end

      if (cmd.srch_start) begin
         srch_in = level_ff - 1'b1;
      end

      if (cmd.srch_step) begin
         srch_in = srch_ff - 1'b1;
      end

      if (cmd.srch_done) begin
         level_in      = srch_ff;
         top_in        = srch_col;
         res_level_in  = srch_ff;
         res_spaces_in = spaces_ff;
         res_status_in = (column_ff != srch_col) ? ST_DEDENT : ST_OK;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = LEVEL_OUT_BITS'(res_level_ff);
         rsp_spaces_in = res_spaces_ff;
         rsp_status_in = res_status_ff;
         column_in     = '0;
         spaces_in     = '0;
         lead_in       = 1'b1;
         saw_in        = 1'b0;
         cmt_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         spaces_ff    <= '0;
         lead_ff      <= 1'b1;
         saw_ff       <= 1'b0;
         cmt_ff       <= 1'b0;
         level_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         spaces_ff    <= spaces_in;
         lead_ff      <= lead_in;
         saw_ff       <= saw_in;
         cmt_ff       <= cmt_in;
         level_ff     <= level_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      srch_ff       <= srch_in;
      res_level_ff  <= res_level_in;
      res_spaces_ff <= res_spaces_in;
      res_status_ff <= res_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_spaces_ff <= rsp_spaces_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[level_ff + 1'b1] <= column_ff;
      end
      if (cmd.srch_read) begin
         rd_ff <= stack_mem[srch_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_level  = rsp_level_ff;
   assign rsp_spaces = rsp_spaces_ff;
   assign rsp_status = rsp_status_ff;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= TOP_LEVEL)
      else $error("Nesting level beyond the stack.");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("Result written over a waiting word.");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (top_ff == $past(column_ff)) && (level_ff == $past(level_ff) + 1'b1))
      else $error("Push did not move the top of the stack.");

   a_srch_below: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_read |-> (srch_ff < level_ff))
      else $error("Dedent search above the current level.");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_done && (column_ff == srch_col) |=> top_ff == $past(column_ff))
      else $error("Matched dedent left a wrong top column.");

endmodule

// ===== design/indent_nesting_tracker_core.sv =====
// Channel  Direction  tdata                          tuser          tlast
// req      in         [7:0] text_byte                [1:0] command  line_end
// rsp      out        [5:0] level, [17:6] spaces     [1:0] status   none
//
// A byte that does not end a line, a restart or an unused command is taken in the idle state.
// A finished line passes the finish step, then on a dedent the search, which reads the indent
// stack memory one level at a time through its registered port, then the emit step. An empty
// line goes straight to the emit step. Reset is synchronous and clears the level to zero.
// The result register lets input flow while a word waits; a new result waits for rsp_tready.
module indent_nesting_tracker_core
   import ints_pkg::*;
#(
   parameter int MAX_DEPTH   = 50,
   parameter int COLUMN_BITS = 12
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // text_byte
   input  logic [CMD_BITS-1:0]      req_tuser,  // command
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // level, leading_spaces, zero fill
   output logic [STATUS_BITS-1:0]   rsp_tuser   // status
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   logic [LEVEL_OUT_BITS-1:0] rsp_level;
   logic [SPACE_BITS-1:0]     rsp_spaces;

   ints_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ints_dp #(
      .MAX_DEPTH   (MAX_DEPTH),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_level  (rsp_level),
      .rsp_spaces (rsp_spaces),
      .rsp_status (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - SPACE_BITS - LEVEL_OUT_BITS){1'b0}},
                       rsp_spaces, rsp_level};

endmodule

// ===== bench/tb_indent_nesting_tracker_core.sv =====
`timescale 1ns / 100ps

module tb_indent_nesting_tracker_core;
   import ints_pkg::*;

   localparam int MAX_DEPTH   = 50;
   localparam int COLUMN_BITS = 12;
   localparam int COL_MAX     = (1 << COLUMN_BITS) - 1;
   localparam int SPACE_MAX   = (1 << SPACE_BITS) - 1;
   localparam int RANDOM_WORDS = 1800;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam logic [7:0] CHAR_LETTER = 8'h61;

   class line_scoreboard;
      typedef struct {
         logic [LEVEL_OUT_BITS-1:0] level;
         logic [SPACE_BITS-1:0]     spaces;
         logic [STATUS_BITS-1:0]    status;
      } line_result_type;

      line_result_type expected_lines[$];
      int stack_col[0:MAX_DEPTH];
      int depth_now;
      int column;
      int spaces;
      bit in_lead;
      bit saw_text;
      bit is_comment;
      int errors;

      function new();
         foreach (stack_col[i]) stack_col[i] = 0;
         depth_now = 0;
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         column = 0;
         spaces = 0;
         in_lead = 1'b1;
         saw_text = 1'b0;
         is_comment = 1'b0;
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function logic [STATUS_BITS-1:0] close_line();
         int col;
         int cur;
         col = column;
         if (!saw_text || is_comment) return ST_OK;
         if (depth_now > MAX_DEPTH) depth_now = 0;
         cur = stack_col[depth_now];
         if (col == cur) return ST_OK;
         if (col > cur) begin
            if (depth_now + 1 >= MAX_DEPTH) return ST_DEEP;
            depth_now++;
            stack_col[depth_now] = col;
            return ST_OK;
         end
         if (depth_now > 0) depth_now--;
         while (depth_now > 0 && col < stack_col[depth_now]) depth_now--;
         return (col != stack_col[depth_now]) ? ST_DEDENT : ST_OK;
      endfunction

      function void note_word(logic [CMD_BITS-1:0] cmd, logic [7:0] ch, logic last);
         line_result_type r;
         if (cmd == CMD_RESTART) begin
            depth_now = 0;
            return;
         end
         if (cmd == CMD_EMPTY) begin
            clear_line();
            r.level = depth_now[LEVEL_OUT_BITS-1:0];
            r.spaces = '0;
            r.status = ST_OK;
            expected_lines.push_back(r);
            return;
         end
         if (cmd != CMD_BYTE) return;
         if (in_lead) begin
            if (ch == CHAR_SPACE) begin
               if (column < COL_MAX) column++;
               if (spaces < SPACE_MAX) spaces++;
            end else if (ch == CHAR_TAB) begin
               column = column + (TAB_MASK + 1) - (column & TAB_MASK);
               if (column > COL_MAX) column = COL_MAX;
               if (spaces < SPACE_MAX) spaces++;
            end else begin
               in_lead = 1'b0;
               saw_text = 1'b1;
               is_comment = (ch == CHAR_HASH);
            end
         end
         if (!last) return;
         r.status = close_line();
         r.level = depth_now[LEVEL_OUT_BITS-1:0];
         r.spaces = spaces[SPACE_BITS-1:0];
         expected_lines.push_back(r);
         clear_line();
      endfunction

      task check_word(logic [LEVEL_OUT_BITS-1:0] lvl, logic [SPACE_BITS-1:0] sp,
                      logic [STATUS_BITS-1:0] st);
         line_result_type r;
         if (expected_lines.size() == 0) begin
            report_mismatch($sformatf("unexpected word level %0d spaces %0d status %0d",
                                      lvl, sp, st));
            return;
         end
         r = expected_lines.pop_front();
         if (lvl !== r.level)
            report_mismatch($sformatf("level %0d, wanted %0d", lvl, r.level));
         if (sp !== r.spaces)
            report_mismatch($sformatf("leading spaces %0d, wanted %0d", sp, r.spaces));
         if (st !== r.status)
            report_mismatch($sformatf("status %0d, wanted %0d", st, r.status));
      endtask

      task check_drained();
         if (expected_lines.size() != 0)
            report_mismatch($sformatf("%0d lines never produced a word",
                                      expected_lines.size()));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [CMD_BITS-1:0]      req_tuser = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;

   line_scoreboard book;
   bit idle_mode = 1'b1;
   bit quiet = 1'b0;
   int words_sent = 0;
   int cycle_count = 0;

   indent_nesting_tracker_core #(
      .MAX_DEPTH(MAX_DEPTH),
      .COLUMN_BITS(COLUMN_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_indent_nesting_tracker_core: FAIL");
      $finish;
   end

   task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [7:0] ch,
                            input logic last);
      int gap;
      gap = 0;
      if (!quiet && idle_mode && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= ch;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      book.note_word(cmd, ch, last);
      if (cmd != CMD_UNUSED) words_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.expected_lines.size() != 0);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(CMD_BYTE, s[i], i == s.len() - 1);
   endtask

   task automatic send_indent(input int target);
      int col;
      int step;
      col = 0;
      while (col < target) begin
         step = (TAB_MASK + 1) - (col & TAB_MASK);
         if (col + step <= target && $urandom_range(0, 1) == 1) begin
            send_word(CMD_BYTE, CHAR_TAB, 1'b0);
            col += step;
         end else begin
            send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
            col++;
         end
      end
   endtask

   task automatic random_line();
      int target;
      int len;
      logic [7:0] ch;
      case ($urandom_range(0, 4))
         0: target = book.stack_col[book.depth_now];
         1: target = book.stack_col[book.depth_now] + $urandom_range(1, 16);
         2, 3: target = book.stack_col[$urandom_range(0, book.depth_now)];
         default: target = $urandom_range(0, 40);
      endcase
      if (target > 64) target = $urandom_range(0, 64);
      send_indent(target);
      if ($urandom_range(0, 19) == 0) begin
         send_word(CMD_BYTE, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b1);
         return;
      end
      if ($urandom_range(0, 5) == 0) begin
         ch = CHAR_HASH;
      end else begin
         ch = 8'($urandom_range(0, 255));
         if (ch == CHAR_SPACE || ch == CHAR_TAB) ch = CHAR_LETTER;
      end
      len = $urandom_range(0, 4);
      send_word(CMD_BYTE, ch, len == 0);
      for (int i = 1; i <= len; i++)
         send_word(CMD_BYTE, 8'($urandom_range(0, 255)), i == len);
   endtask

   // Climbs one column per line past the depth the stack can hold, then falls back to column zero.
   task automatic climb_to_limit();
      send_word(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_word(CMD_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (int k = 1; k <= MAX_DEPTH + 2; k++) begin
         repeat (k / (TAB_MASK + 1)) send_word(CMD_BYTE, CHAR_TAB, 1'b0);
         repeat (k & TAB_MASK) send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
         send_word(CMD_BYTE, CHAR_LETTER, 1'b1);
      end
      send_word(CMD_BYTE, CHAR_LETTER, 1'b1);
   endtask

   // Pushes the column count into saturation.
   task automatic send_long_line();
      send_word(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      repeat (3) send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
      repeat (515) send_word(CMD_BYTE, CHAR_TAB, 1'b0);
      repeat (3) send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
      send_word(CMD_BYTE, CHAR_LETTER, 1'b1);
   endtask

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            book.check_word(rsp_tdata[LEVEL_OUT_BITS-1:0],
                            rsp_tdata[LEVEL_OUT_BITS+SPACE_BITS-1:LEVEL_OUT_BITS], rsp_tuser);
         if (stall == 0 && !quiet && idle_mode && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int start;
      int progress;
      int pick;
      bit climbed;
      bit paused;
      bit long_done;
      book = new();
      climbed = 1'b0;
      paused = 1'b0;
      long_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("x");
      send_text("  a");
      send_text("\tb");
      send_text("   c");
      send_text("  #c");
      send_text(" \t ");
      send_word(CMD_EMPTY, 8'hFF, 1'b1);
      send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
      send_word(CMD_EMPTY, 8'h00, 1'b0);
      send_word(CMD_RESTART, 8'hA5, 1'b1);
      send_word(CMD_UNUSED, 8'h5A, 1'b0);
      send_word(CMD_BYTE, 8'hFF, 1'b1);
      send_word(CMD_BYTE, 8'h00, 1'b1);
      send_word(CMD_BYTE, CHAR_SPACE, 1'b0);
      send_word(CMD_RESTART, 8'h00, 1'b0);
      send_text("y");

      start = words_sent;
      progress = 0;
      while (progress < RANDOM_WORDS) begin
         if (!climbed && progress >= 300) begin
            climb_to_limit();
            climbed = 1'b1;
         end
         if (!paused && progress >= 800) begin
            wait_for_results();
            paused = 1'b1;
         end
         if (!long_done && progress >= 1000) begin
            send_long_line();
            long_done = 1'b1;
         end
         quiet = (progress >= RANDOM_WORDS * 85 / 100);
         if ($urandom_range(0, 30) == 0) idle_mode = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            random_line();
         else if (pick < 80)
            send_word(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else if (pick < 85)
            send_word(CMD_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else if (pick < 90)
            send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else
            send_word(CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         progress = words_sent - start;
      end

      wait_for_results();
      repeat (200) @(posedge clock);
      book.check_drained();
      if (book.errors == 0) begin
         $display("tb_indent_nesting_tracker_core: PASS");
      end else begin
         $display("tb_indent_nesting_tracker_core: FAIL");
      end
      $finish;
   end

endmodule
